@@ rtl/pfa_pkg.sv @@
// ----------------------------------------------------------------------------
// pfa_pkg: shared definitions of the page frame allocator
// Field widths, default sizing, register indexes, actions and status codes.
// ----------------------------------------------------------------------------
package pfa_pkg;

	localparam int ADDR_W  = 48;
	localparam int COUNT_W = 11;

	localparam int DEF_MAX_FRAMES = 1024;
	localparam int DEF_PAGE_BYTES = 4096;

	// Frame count after reset, before saturation to the table size.
	localparam int COUNT_RESET = 1024;

	typedef enum logic {
		REG_BASE  = 1'b0,
		REG_COUNT = 1'b1
	} reg_index_t;

	typedef enum logic {
		ACTION_ALLOC = 1'b0,
		ACTION_FREE  = 1'b1
	} action_t;

	typedef enum logic [1:0] {
		STATUS_DONE        = 2'd0,
		STATUS_EXHAUSTED   = 2'd1,
		STATUS_BAD_ADDRESS = 2'd2
	} status_t;

endpackage

@@ rtl/pfa_ram.sv @@
// ----------------------------------------------------------------------------
// pfa_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; the read data is registered.
// ----------------------------------------------------------------------------
module pfa_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 2
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/page_frame_allocator.sv @@
// ----------------------------------------------------------------------------
// page_frame_allocator: free-list allocator of fixed-size physical page frames
// Frame i lies at base + i * PAGE_BYTES. Free frames sit on a LIFO stack in
// one RAM; a second RAM holds one allocated bit per frame.
// ----------------------------------------------------------------------------
// Usage: an input item carries an action (allocate or free) and, for a free,
// the frame address. Every item gives exactly one result item with the
// allocated frame address (zero otherwise) and a status code. Both channels
// use valid and stall.
// An item is accepted and its RAM reads are issued at once; the result is
// registered at the end of the cycle in which the read data lands. The
// input stalls while an item is in flight, for the registered RAM reads and
// the stack pointer's read-modify-write, so no new item is taken before the
// last one's result is registered. While a result waits on a receiver stall,
// the input stalls too; a result taken in the same cycle frees the slot.
// Reset and any configuration write restore the starting state at once:
// frames 0..count-1 free, with count saturated to MAX_FRAMES and the highest
// on top, nothing allocated. No RAM clearing pass is needed: a low-water mark
// of the stack depth tells which stack entries and allocated bits have been
// written since then. PAGE_BYTES must be a power of two.
// ----------------------------------------------------------------------------
module page_frame_allocator #(
	parameter int MAX_FRAMES = pfa_pkg::DEF_MAX_FRAMES,
	parameter int PAGE_BYTES = pfa_pkg::DEF_PAGE_BYTES
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_write,
	input  logic                      cfg_index,
	input  logic [pfa_pkg::ADDR_W-1:0] cfg_data,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      action,
	input  logic [pfa_pkg::ADDR_W-1:0] address,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [pfa_pkg::ADDR_W-1:0] frame_address,
	output logic [1:0]                status
);

	localparam int ADDR_W     = pfa_pkg::ADDR_W;
	localparam int COUNT_W    = pfa_pkg::COUNT_W;
	localparam int IDX_W      = $clog2(MAX_FRAMES);
	localparam int DEPTH_W    = $clog2(MAX_FRAMES + 1);
	localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
	localparam int PAGE_W     = ADDR_W - PAGE_SHIFT;
	localparam int CMP_W      = (COUNT_W > DEPTH_W) ? COUNT_W : DEPTH_W;
	localparam int RESET_EFF  = (pfa_pkg::COUNT_RESET > MAX_FRAMES) ?
		MAX_FRAMES : pfa_pkg::COUNT_RESET;

	function automatic logic [DEPTH_W-1:0] sat_count(input logic [COUNT_W-1:0] cnt);
		logic [CMP_W-1:0] cnt_ext;
		cnt_ext = CMP_W'(cnt);
		if (cnt_ext > CMP_W'(MAX_FRAMES)) begin
			return DEPTH_W'(MAX_FRAMES);
		end
		return DEPTH_W'(cnt_ext);
	endfunction

	logic [ADDR_W-1:0]  base_q;
	logic [COUNT_W-1:0] count_q;
	logic [DEPTH_W-1:0] depth_q;
	logic [DEPTH_W-1:0] low_q;
	logic               busy_q;
	pfa_pkg::action_t   act_s1;
	logic               free_ok_s1;
	logic [IDX_W-1:0]   idx_s1;
	logic               out_valid_q;
	logic [ADDR_W-1:0]  frame_address_q;
	pfa_pkg::status_t   status_q;

	logic               accept;
	logic [DEPTH_W-1:0] eff_count;
	logic [DEPTH_W-1:0] eff_new;
	logic [COUNT_W-1:0] count_new;
	logic [ADDR_W-1:0]  offset;
	logic [PAGE_W-1:0]  page;
	logic               aligned;
	logic               in_range;
	logic [DEPTH_W-1:0] pos_full;
	logic [IDX_W-1:0]   pos;

	logic [IDX_W-1:0]   stack_rdata;
	logic               stack_we;
	logic               map_rdata;
	logic               map_we;
	logic [IDX_W-1:0]   map_waddr;
	logic               map_wdata;

	logic               empty;
	logic               stack_fresh;
	logic [IDX_W-1:0]   alloc_idx;
	logic               marked;
	logic               free_ok;

	assign in_stall = busy_q | (out_valid_q & out_stall);
	assign accept   = in_valid & ~in_stall;

	assign eff_count = sat_count(count_q);
	assign count_new = (pfa_pkg::reg_index_t'(cfg_index) == pfa_pkg::REG_COUNT) ?
		cfg_data[COUNT_W-1:0] : count_q;
	assign eff_new   = sat_count(count_new);

	// Address decode of a free, done in the accept cycle so the map read
	// can be issued at once.
	assign offset   = address - base_q;
	assign page     = offset[ADDR_W-1:PAGE_SHIFT];
	assign aligned  = (offset[PAGE_SHIFT-1:0] == '0);
	assign in_range = (page < PAGE_W'(eff_count));

	// Top of stack; only used when the depth is nonzero.
	assign pos_full = depth_q - DEPTH_W'(1);
	assign pos      = pos_full[IDX_W-1:0];

	// A stack position below the low-water mark has never been written since
	// the last rebuild, so it still holds its own index. The same holds for
	// the allocated bit of any frame index below the mark: it reads as clear.
	assign empty       = (depth_q == '0);
	assign stack_fresh = (pos_full < low_q);
	assign alloc_idx   = stack_fresh ? pos : stack_rdata;
	assign marked      = (DEPTH_W'(idx_s1) >= low_q) & map_rdata;
	assign free_ok     = free_ok_s1 & marked;

	assign stack_we  = busy_q & (act_s1 == pfa_pkg::ACTION_FREE) & free_ok;
	assign map_we    = busy_q & ((act_s1 == pfa_pkg::ACTION_ALLOC) ? ~empty : free_ok);
	assign map_waddr = (act_s1 == pfa_pkg::ACTION_ALLOC) ? alloc_idx : idx_s1;
	assign map_wdata = (act_s1 == pfa_pkg::ACTION_ALLOC);

	pfa_ram #(
		.WIDTH (IDX_W),
		.DEPTH (MAX_FRAMES)
	) u_stack_ram (
		.clk   (clk),
		.we    (stack_we),
		.waddr (depth_q[IDX_W-1:0]),
		.wdata (idx_s1),
		.raddr (pos),
		.rdata (stack_rdata)
	);

	pfa_ram #(
		.WIDTH (1),
		.DEPTH (MAX_FRAMES)
	) u_map_ram (
		.clk   (clk),
		.we    (map_we),
		.waddr (map_waddr),
		.wdata (map_wdata),
		.raddr (page[IDX_W-1:0]),
		.rdata (map_rdata)
	);

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q      <= '0;
			count_q     <= COUNT_W'(pfa_pkg::COUNT_RESET);
			depth_q     <= DEPTH_W'(RESET_EFF);
			low_q       <= DEPTH_W'(RESET_EFF);
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			priority if (cfg_write) begin
				unique case (pfa_pkg::reg_index_t'(cfg_index))
					pfa_pkg::REG_BASE:  base_q  <= cfg_data;
					pfa_pkg::REG_COUNT: count_q <= cfg_data[COUNT_W-1:0];
					default:            base_q  <= base_q;
				endcase
				depth_q <= eff_new;
				low_q   <= eff_new;
			end else if (busy_q) begin
				if (act_s1 == pfa_pkg::ACTION_ALLOC) begin
					if (!empty) begin
						depth_q <= pos_full;
						if (stack_fresh) begin
							low_q <= pos_full;
						end
					end
				end else if (free_ok) begin
					depth_q <= depth_q + DEPTH_W'(1);
				end
			end

			busy_q <= accept;

			if (busy_q) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			act_s1     <= pfa_pkg::action_t'(action);
			free_ok_s1 <= aligned & in_range & (depth_q < DEPTH_W'(MAX_FRAMES));
			idx_s1     <= page[IDX_W-1:0];
		end
		if (busy_q) begin
			if (act_s1 == pfa_pkg::ACTION_ALLOC) begin
				if (empty) begin
					frame_address_q <= '0;
					status_q        <= pfa_pkg::STATUS_EXHAUSTED;
				end else begin
					frame_address_q <= base_q + (ADDR_W'(alloc_idx) << PAGE_SHIFT);
					status_q        <= pfa_pkg::STATUS_DONE;
				end
			end else begin
				frame_address_q <= '0;
				status_q        <= free_ok ? pfa_pkg::STATUS_DONE :
					pfa_pkg::STATUS_BAD_ADDRESS;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign frame_address = frame_address_q;
	assign status        = status_q;

endmodule

@@ verif/tb_page_frame_allocator.sv @@
// ----------------------------------------------------------------------------
// tb_page_frame_allocator: self-checking regression of the page frame allocator
// A queue-fed driver sends allocate and free items while a monitor predicts each
// reply from a shadow free stack and allocated map, then checks every result in
// order. Directed corner items come first, then random phases over several
// base and count settings, most with random sender gaps or receiver stalls.
// ----------------------------------------------------------------------------
module tb_page_frame_allocator;

	localparam int ADDR_W          = pfa_pkg::ADDR_W;
	localparam int COUNT_W         = pfa_pkg::COUNT_W;
	localparam int FRAMES          = pfa_pkg::DEF_MAX_FRAMES;
	localparam int PAGE            = pfa_pkg::DEF_PAGE_BYTES;
	localparam int IDX_W           = $clog2(FRAMES);
	localparam int SETTLE_CYCLES   = 4;
	localparam int QUIET_LIMIT     = 2000;
	localparam int PHASES          = 8;
	localparam int CHUNK           = 20;
	localparam int CHUNKS_PER_PHASE = 7;
	localparam int PRINT_LIMIT     = 50;

	typedef struct {
		pfa_pkg::action_t  act;
		logic [ADDR_W-1:0] addr;
	} request_t;

	typedef struct packed {
		logic [ADDR_W-1:0] frame_address;
		pfa_pkg::status_t  status;
	} reply_t;

	logic                clk;
	logic                arst_n = 1'b0;
	logic                cfg_write = 1'b0;
	pfa_pkg::reg_index_t cfg_index = pfa_pkg::REG_BASE;
	logic [ADDR_W-1:0]   cfg_data = '0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	pfa_pkg::action_t    action = pfa_pkg::ACTION_ALLOC;
	logic [ADDR_W-1:0]   address = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [ADDR_W-1:0]   frame_address;
	logic [1:0]          status;

	// Shadow of the allocator state and its registers.
	logic [ADDR_W-1:0]  cfg_base;
	logic [COUNT_W-1:0] cfg_count;
	logic [IDX_W-1:0]   free_stack [FRAMES];
	logic [COUNT_W-1:0] free_depth;
	logic               frame_taken [FRAMES];

	request_t    pending_requests [$];
	reply_t      awaited_replies [$];
	int unsigned mismatch_count = 0;
	int unsigned quiet_cycles = 0;
	int unsigned sender_idle_pct = 0;
	int unsigned receiver_stall_pct = 0;

	int unsigned mode_idle [4] = '{0, 85, 0, 36};
	int unsigned mode_stall [4] = '{0, 0, 85, 36};
	int unsigned alloc_bias [4] = '{25, 50, 75, 90};

	page_frame_allocator uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.action       (action),
		.address      (address),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.frame_address(frame_address),
		.status       (status)
	);

	function automatic logic [COUNT_W-1:0] usable_frames();
		return (cfg_count > COUNT_W'(FRAMES)) ? COUNT_W'(FRAMES) : cfg_count;
	endfunction

	function automatic void rebuild_free_list();
		for (int i = 0; i < FRAMES; i++) begin
			free_stack[i] = IDX_W'(i);
			frame_taken[i] = 1'b0;
		end
		free_depth = usable_frames();
	endfunction

	function automatic void apply_register(pfa_pkg::reg_index_t idx,
			logic [ADDR_W-1:0] data);
		if (idx == pfa_pkg::REG_BASE) begin
			cfg_base = data;
		end else begin
			cfg_count = data[COUNT_W-1:0];
		end
		rebuild_free_list();
	endfunction

	function automatic reply_t predict_reply(pfa_pkg::action_t act, logic [ADDR_W-1:0] addr);
		reply_t            r;
		logic [IDX_W-1:0]  frame;
		logic [ADDR_W-1:0] offset;
		logic [ADDR_W-1:0] page_no;
		r.frame_address = '0;
		r.status = pfa_pkg::STATUS_DONE;
		if (act == pfa_pkg::ACTION_ALLOC) begin
			if (free_depth == 0) begin
				r.status = pfa_pkg::STATUS_EXHAUSTED;
			end else begin
				free_depth--;
				frame = free_stack[free_depth];
				frame_taken[frame] = 1'b1;
				r.frame_address = cfg_base + ADDR_W'(frame) * ADDR_W'(PAGE);
			end
		end else begin
			// An address below the base wraps to a huge offset and fails the range test.
			offset = addr - cfg_base;
			page_no = offset / PAGE;
			if (offset % PAGE != 0 || page_no >= ADDR_W'(usable_frames())
					|| page_no >= ADDR_W'(FRAMES)
					|| !frame_taken[page_no[IDX_W-1:0]]
					|| free_depth >= COUNT_W'(FRAMES)) begin
				r.status = pfa_pkg::STATUS_BAD_ADDRESS;
			end else begin
				frame_taken[page_no[IDX_W-1:0]] = 1'b0;
				free_stack[free_depth] = page_no[IDX_W-1:0];
				free_depth++;
			end
		end
		return r;
	endfunction

	// Most frees aim at frames near the top of the stack, where allocations come
	// from, so that a good share of them find an allocated frame.
	function automatic request_t random_request(logic [ADDR_W-1:0] base, int unsigned usable,
			int unsigned alloc_pct);
		request_t    req;
		logic [63:0] wide;
		int unsigned reach;
		int unsigned slot;
		wide = {$urandom, $urandom};
		req.act = pfa_pkg::ACTION_FREE;
		req.addr = wide[ADDR_W-1:0];
		if ($urandom_range(99) < 12) begin
			case ($urandom_range(3))
				0: req.addr = wide[ADDR_W-1:0];
				1: req.addr = base + ADDR_W'($urandom_range(usable)) * ADDR_W'(PAGE)
						+ ADDR_W'($urandom_range(PAGE - 1, 1));
				2: req.addr = base - ADDR_W'($urandom_range(4, 1)) * ADDR_W'(PAGE);
				default: req.addr = base + ADDR_W'(usable + $urandom_range(3)) * ADDR_W'(PAGE);
			endcase
		end else if ($urandom_range(99) < alloc_pct) begin
			req.act = pfa_pkg::ACTION_ALLOC;
		end else begin
			reach = (usable < 96) ? usable : 96;
			slot = (usable == 0) ? 0 : usable - 1 - $urandom_range(reach - 1);
			req.addr = base + ADDR_W'(slot) * ADDR_W'(PAGE);
		end
		return req;
	endfunction

	task automatic report_mismatch(string what);
		if (mismatch_count < PRINT_LIMIT) begin
			$display("%0t: mismatch: %s", $time, what);
		end
		mismatch_count++;
	endtask

	task automatic push_request(pfa_pkg::action_t act, logic [ADDR_W-1:0] addr);
		request_t req;
		req.act = act;
		req.addr = addr;
		pending_requests.push_back(req);
	endtask

	task automatic wait_until_drained();
		do @(negedge clk);
		while (pending_requests.size() != 0 || in_valid || awaited_replies.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_register(pfa_pkg::reg_index_t idx, logic [ADDR_W-1:0] data);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		apply_register(idx, data);
	endtask

	task automatic reconfigure(logic [ADDR_W-1:0] base, logic [COUNT_W-1:0] count);
		wait_until_drained();
		write_register(pfa_pkg::REG_BASE, base);
		write_register(pfa_pkg::REG_COUNT, ADDR_W'(count));
		@(posedge clk);
		cfg_write <= 1'b0;
		@(negedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk or negedge arst_n) begin : drive_requests
		request_t req;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || !in_stall) begin
			if (pending_requests.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
				req = pending_requests.pop_front();
				in_valid <= 1'b1;
				action <= req.act;
				address <= req.addr;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= ($urandom_range(99) < receiver_stall_pct);
		end
	end

	always @(posedge clk) begin : check_replies
		reply_t want;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				awaited_replies.push_back(predict_reply(action, address));
			end
			if (out_valid && !out_stall) begin
				if (awaited_replies.size() == 0) begin
					report_mismatch($sformatf("result %h/%0d with nothing awaited",
						frame_address, status));
				end else begin
					want = awaited_replies.pop_front();
					if (frame_address !== want.frame_address) begin
						report_mismatch($sformatf("frame_address %h, expected %h",
							frame_address, want.frame_address));
					end
					if (status !== want.status) begin
						report_mismatch($sformatf("status %0d, expected %0d",
							status, want.status));
					end
				end
			end
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				quiet_cycles <= 0;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin : watchdog
		do @(negedge clk);
		while (quiet_cycles < QUIET_LIMIT);
		$display("page_frame_allocator regression: fail");
		$finish;
	end

	initial begin : stimulus
		logic [ADDR_W-1:0]  phase_base [PHASES];
		logic [COUNT_W-1:0] phase_count [PHASES];
		logic [63:0]        wide;
		int unsigned        bias;

		cfg_base = '0;
		cfg_count = COUNT_W'(pfa_pkg::COUNT_RESET);
		rebuild_free_list();

		phase_base = '{48'h0, 48'hFFFF_FFFF_F000, 48'h0, 48'h0, 48'h5000, 48'h0,
			48'h0, 48'hFFFF_FFF0_0000};
		phase_count = '{11'd8, 11'd16, 11'd1, 11'd1024, 11'd40, 11'd2, 11'd1025, 11'd64};
		foreach (phase_base[p]) begin
			if (p == 2 || p == 3 || p == 5) begin
				wide = {$urandom, $urandom};
				phase_base[p] = wide[ADDR_W-1:0] & ~ADDR_W'(PAGE - 1);
			end
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset state: 1024 frames from address zero, frame 1023 on top.
		push_request(pfa_pkg::ACTION_ALLOC, 48'h0);
		push_request(pfa_pkg::ACTION_FREE, 48'h3F_F000);
		push_request(pfa_pkg::ACTION_FREE, 48'h3F_F000);
		push_request(pfa_pkg::ACTION_ALLOC, 48'hFFFF_FFFF_FFFF);
		push_request(pfa_pkg::ACTION_ALLOC, 48'h0);
		push_request(pfa_pkg::ACTION_FREE, 48'h3F_E001);
		push_request(pfa_pkg::ACTION_FREE, 48'h3F_EFFF);
		push_request(pfa_pkg::ACTION_FREE, 48'h40_0000);
		push_request(pfa_pkg::ACTION_FREE, 48'hFFFF_FFFF_FFFF);
		push_request(pfa_pkg::ACTION_FREE, 48'h3F_E000);
		push_request(pfa_pkg::ACTION_FREE, 48'h0);

		// Frames straddle the top of the address space, so frame 2 lands on zero.
		reconfigure(48'hFFFF_FFFF_E000, 11'd3);
		repeat (4) push_request(pfa_pkg::ACTION_ALLOC, 48'h0);
		push_request(pfa_pkg::ACTION_FREE, 48'h0);
		push_request(pfa_pkg::ACTION_FREE, 48'h1000);
		push_request(pfa_pkg::ACTION_FREE, 48'hFFFF_FFFF_D000);
		push_request(pfa_pkg::ACTION_FREE, 48'hFFFF_FFFF_E000);

		reconfigure(48'h0, 11'd0);
		push_request(pfa_pkg::ACTION_ALLOC, 48'h0);
		push_request(pfa_pkg::ACTION_FREE, 48'h0);

		// A count beyond the table size saturates.
		reconfigure(48'h1000, 11'd2047);
		push_request(pfa_pkg::ACTION_ALLOC, 48'h0);
		push_request(pfa_pkg::ACTION_FREE, 48'h40_1000);
		push_request(pfa_pkg::ACTION_FREE, 48'h40_0000);

		for (int p = 0; p < PHASES; p++) begin
			reconfigure(phase_base[p], phase_count[p]);
			sender_idle_pct = mode_idle[p % 4];
			receiver_stall_pct = mode_stall[p % 4];
			for (int c = 0; c < CHUNKS_PER_PHASE; c++) begin
				bias = alloc_bias[$urandom_range(3)];
				// Now and then the sender holds off until every reply is back.
				if (c % 3 == 2) begin
					wait_until_drained();
				end else begin
					@(negedge clk);
				end
				repeat (CHUNK) begin
					pending_requests.push_back(random_request(phase_base[p],
						int'(usable_frames()), bias));
				end
			end
		end

		wait_until_drained();
		if (mismatch_count == 0) begin
			$display("page_frame_allocator regression: pass");
		end else begin
			$display("page_frame_allocator regression: fail");
		end
		$finish;
	end

endmodule
